// File: hdl/logo_module_parser_core_defines.svh
// assertion helpers for the logo module parser
`ifndef LOGO_MODULE_PARSER_CORE_DEFINES_SVH
`define LOGO_MODULE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/logo_mp_pkg.sv
package logo_mp_pkg;

  // fixed field widths
  localparam int unsigned ModSizeW = 20;

  // result kinds
  localparam logic [1:0] KindSvc  = 2'd0;
  localparam logic [1:0] KindHdr  = 2'd1;
  localparam logic [1:0] KindData = 2'd2;
  localparam logic [1:0] KindEnd  = 2'd3;

  // module end status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StReject = 2'd1;
  localparam logic [1:0] StTrunc  = 2'd2;

  // largest accepted logo type
  localparam logic [7:0] MaxLogoType = 8'h05;
  // smallest accepted module size
  localparam int unsigned MinModSize = 3;

  // result buffer
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  logo_type;
    logic [8:0]  logo_id;
    logic [15:0] network_id;
    logic [15:0] stream_id;
    logic [15:0] service_id;
    logic [7:0]  service_count;
    logic [15:0] data_size;
    logic        deliver;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
  } res_t;

  // results of one byte: a first result and an optional trailing module end
  typedef struct packed {
    res_t       res;
    logic       two;
    logic [1:0] end_status;
  } pair_t;

endpackage

// File: hdl/logo_mp_if.sv
// byte channel into the parser
interface logo_mp_in_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        data_byte;
  logic                              first;
  logic [logo_mp_pkg::ModSizeW-1:0]  module_size;

  modport source (output valid, output data_byte, output first, output module_size,
                  input ready);
  modport sink (input valid, input data_byte, input first, input module_size,
                output ready);
endinterface

// result channel out of the parser
interface logo_mp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  logo_type;
  logic [8:0]  logo_id;
  logic [15:0] network_id;
  logic [15:0] stream_id;
  logic [15:0] service_id;
  logic [7:0]  service_count;
  logic [15:0] data_size;
  logic        deliver;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output logo_type, output logo_id,
                  output network_id, output stream_id, output service_id,
                  output service_count, output data_size, output deliver,
                  output payload_byte, output status, output last, input ready);
  modport sink (input valid, input kind, input logo_type, input logo_id,
                input network_id, input stream_id, input service_id,
                input service_count, input data_size, input deliver,
                input payload_byte, input status, input last, output ready);
endinterface

// File: hdl/logo_module_parser_core.sv
// Logo data module parser.
// in_i carries one module byte per transaction with a first flag and the
// module size (sampled with the first byte). out_o carries the results:
// service records, an entry header with a deliver flag, delivered logo data
// bytes and one module end status; last marks the final result of a byte.
// A header byte, count or size byte, or an undelivered data byte may cause
// no result; a byte causes at most two.
// A byte is registered on accept, then parsed into a four-entry result
// buffer from which its results leave on out_o.
// Throughput: one byte per cycle while the result buffer has room. The
// parse step is combinational compare and counter logic; the two results
// of a byte that yields two are sent in turn from one buffer entry.
// Reset: the parser goes idle and ignores bytes until one with first set.
// A stalled receiver fills the result buffer; when it has no room, the
// parse stage holds its byte and in_i.ready stays low while that byte waits
// (an empty input register still takes one byte before ready drops).
`include "logo_module_parser_core_defines.svh"

module logo_module_parser_core #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  logo_mp_in_if.sink           in_i,
  logo_mp_out_if.source        out_o
);

  logic                                 in_vld_q;
  logic [7:0]                           in_data_q;
  logic                                 in_first_q;
  logic [logo_mp_pkg::ModSizeW-1:0]     in_size_q;
  logic                                 in_fire;
  logic                                 step_fire;
  logic                                 pair_vld;
  logo_mp_pkg::pair_t                   pair;

  logo_mp_pkg::pair_t                   fifo_q [logo_mp_pkg::FifoDepth];
  logic [logo_mp_pkg::FifoPtrW-1:0]     wr_q;
  logic [logo_mp_pkg::FifoPtrW-1:0]     rd_q;
  logic [logo_mp_pkg::FifoCntW-1:0]     cnt_q;
  logic                                 sub_q;
  logo_mp_pkg::pair_t                   head;
  logic                                 out_fire;
  logic                                 pop;

  // input register
  assign in_fire   = in_i.valid && in_i.ready;
  assign step_fire = in_vld_q &&
                     (cnt_q < logo_mp_pkg::FifoCntW'(logo_mp_pkg::FifoDepth));
  assign in_i.ready = !in_vld_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q  <= in_i.data_byte;
      in_first_q <= in_i.first;
      in_size_q  <= in_i.module_size;
    end
  end

  // parse step
  logo_mp_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (step_fire),
    .data_byte_i   (in_data_q),
    .first_i       (in_first_q),
    .module_size_i (in_size_q),
    .pair_vld_o    (pair_vld),
    .pair_o        (pair)
  );

  // result buffer, one entry per byte that yields results
  assign head     = fifo_q[rd_q];
  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire && (sub_q || !head.two);

  always_ff @(posedge clk_i) begin
    if (pair_vld) begin
      fifo_q[wr_q] <= pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= 1'b0;
    end else begin
      if (pair_vld) begin
        wr_q <= wr_q + logo_mp_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + logo_mp_pkg::FifoPtrW'(1);
      end
      if (pair_vld && !pop) begin
        cnt_q <= cnt_q + logo_mp_pkg::FifoCntW'(1);
      end else if (!pair_vld && pop) begin
        cnt_q <= cnt_q - logo_mp_pkg::FifoCntW'(1);
      end
      if (out_fire) begin
        sub_q <= !pop;
      end
    end
  end

  // output fields; the second result of a byte is always a module end
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.kind          = sub_q ? logo_mp_pkg::KindEnd : head.res.kind;
  assign out_o.logo_type     = sub_q ? 3'd0  : head.res.logo_type;
  assign out_o.logo_id       = sub_q ? 9'd0  : head.res.logo_id;
  assign out_o.network_id    = sub_q ? 16'd0 : head.res.network_id;
  assign out_o.stream_id     = sub_q ? 16'd0 : head.res.stream_id;
  assign out_o.service_id    = sub_q ? 16'd0 : head.res.service_id;
  assign out_o.service_count = sub_q ? 8'd0  : head.res.service_count;
  assign out_o.data_size     = sub_q ? 16'd0 : head.res.data_size;
  assign out_o.deliver       = sub_q ? 1'b0  : head.res.deliver;
  assign out_o.payload_byte  = sub_q ? 8'd0  : head.res.payload_byte;
  assign out_o.status        = sub_q ? head.end_status : head.res.status;
  assign out_o.last          = sub_q || !head.two;

  // checks
  `LMP_ASSERT_NOW(a_no_overflow, pair_vld, cnt_q < logo_mp_pkg::FifoCntW'(logo_mp_pkg::FifoDepth), "result buffer overflow")
  `LMP_ASSERT_NOW(a_second_is_end, out_o.valid && sub_q, head.two, "second result without pair")
  `LMP_ASSERT_NEXT(a_pair_continues, out_fire && !sub_q && head.two, sub_q && out_o.valid, "module end dropped after first result")
  `LMP_ASSERT_NEXT(a_accept_loads, in_fire, in_vld_q, "accepted byte not held for parsing")

endmodule

// File: hdl/logo_mp_step.sv
module logo_mp_step #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic [7:0]                       data_byte_i,
  input  logic                             first_i,
  input  logic [logo_mp_pkg::ModSizeW-1:0] module_size_i,
  output logic                             pair_vld_o,
  output logo_mp_pkg::pair_t               pair_o
);

  localparam int unsigned PW = SIZE_BITS + 1;
  localparam int unsigned SW = SIZE_BITS + 3;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhEntry = 3'd2;
  localparam logic [2:0] PhSvc   = 3'd3;
  localparam logic [2:0] PhDsize = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhDone  = 3'd6;

  logic [2:0]           phase_q, phase_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [15:0]          entries_q, entries_d;
  logic [2:0]           type_q, type_d;
  logic [8:0]           id_q, id_d;
  logic [7:0]           svc_total_q, svc_total_d;
  logic [7:0]           svc_left_q, svc_left_d;
  logic [39:0]          shift_q, shift_d;
  logic [2:0]           bif_q, bif_d;
  logic [15:0]          bytes_left_q, bytes_left_d;
  logic                 delivering_q, delivering_d;

  logic [PW-1:0]        pos_inc;
  logic [SIZE_BITS-1:0] size_in;
  logic [47:0]          svc_word;
  logic [15:0]          half_word;
  logic [10:0]          six_b;
  logic [7:0]           svc_left_dec;
  logic [15:0]          bytes_left_dec;
  logic                 emit_r0;
  logic                 end_flag;
  logic [1:0]           end_st;
  logic                 do_start;
  logic [15:0]          ent;
  logo_mp_pkg::res_t    r0;
  logo_mp_pkg::res_t    end_res;

  // datapath helpers for the current byte
  assign pos_inc        = pos_q + PW'(1);
  assign size_in        = SIZE_BITS'(module_size_i);
  assign svc_word       = {shift_q, data_byte_i};
  assign half_word      = {shift_q[7:0], data_byte_i};
  assign six_b          = 11'({data_byte_i, 2'b00}) + 11'({data_byte_i, 1'b0});
  assign svc_left_dec   = svc_left_q - 8'd1;
  assign bytes_left_dec = bytes_left_q - 16'd1;

  // one parse step per accepted byte
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    size_d       = size_q;
    entries_d    = entries_q;
    type_d       = type_q;
    id_d         = id_q;
    svc_total_d  = svc_total_q;
    svc_left_d   = svc_left_q;
    shift_d      = shift_q;
    bif_d        = bif_q;
    bytes_left_d = bytes_left_q;
    delivering_d = delivering_q;
    emit_r0      = 1'b0;
    end_flag     = 1'b0;
    end_st       = logo_mp_pkg::StOk;
    do_start     = 1'b0;
    ent          = entries_q;
    r0           = '0;

    if (fire_i) begin
      if (first_i) begin
        // new module: sample size, check header
        size_d       = size_in;
        pos_d        = PW'(1);
        entries_d    = '0;
        id_d         = '0;
        shift_d      = '0;
        bif_d        = '0;
        bytes_left_d = '0;
        delivering_d = 1'b0;
        svc_total_d  = '0;
        svc_left_d   = '0;
        if ((size_in < SIZE_BITS'(logo_mp_pkg::MinModSize)) ||
            (data_byte_i > logo_mp_pkg::MaxLogoType)) begin
          type_d   = '0;
          end_flag = 1'b1;
          end_st   = logo_mp_pkg::StReject;
        end else begin
          type_d  = data_byte_i[2:0];
          phase_d = PhCount;
        end
      end else if (phase_q != PhIdle && phase_q != PhDone) begin
        pos_d = pos_inc;
        case (phase_q)
          PhCount: begin
            shift_d = 40'(half_word);
            bif_d   = bif_q + 3'd1;
            if (bif_q >= 3'd1) begin
              entries_d = half_word;
              ent       = half_word;
              do_start  = 1'b1;
            end
          end
          PhEntry: begin
            if (bif_q == 3'd0) begin
              id_d  = {data_byte_i[0], 8'h00};
              bif_d = 3'd1;
            end else if (bif_q == 3'd1) begin
              id_d  = {id_q[8], data_byte_i};
              bif_d = 3'd2;
            end else begin
              bif_d   = '0;
              shift_d = '0;
              // services plus data size must fit in the module
              if (SW'(pos_inc) + SW'(six_b) + SW'(2) >= SW'(size_q)) begin
                end_flag = 1'b1;
                end_st   = logo_mp_pkg::StTrunc;
              end else begin
                svc_total_d = data_byte_i;
                svc_left_d  = data_byte_i;
                phase_d     = (data_byte_i != 8'd0) ? PhSvc : PhDsize;
              end
            end
          end
          PhSvc: begin
            if (bif_q >= 3'd5) begin
              emit_r0         = 1'b1;
              r0.kind         = logo_mp_pkg::KindSvc;
              r0.logo_type    = type_q;
              r0.logo_id      = id_q;
              r0.network_id   = svc_word[47:32];
              r0.stream_id    = svc_word[31:16];
              r0.service_id   = svc_word[15:0];
              bif_d           = '0;
              shift_d         = '0;
              svc_left_d      = svc_left_dec;
              if (svc_left_dec == 8'd0) begin
                phase_d = PhDsize;
              end
            end else begin
              shift_d = svc_word[39:0];
              bif_d   = bif_q + 3'd1;
            end
          end
          PhDsize: begin
            shift_d = 40'(half_word);
            bif_d   = bif_q + 3'd1;
            if (bif_q >= 3'd1) begin
              bif_d   = '0;
              shift_d = '0;
              if (SW'(pos_inc) + SW'(half_word) > SW'(size_q)) begin
                end_flag = 1'b1;
                end_st   = logo_mp_pkg::StTrunc;
              end else begin
                emit_r0          = 1'b1;
                delivering_d     = (svc_total_q != 8'd0) && (half_word != 16'd0);
                r0.kind          = logo_mp_pkg::KindHdr;
                r0.logo_type     = type_q;
                r0.logo_id       = id_q;
                r0.service_count = svc_total_q;
                r0.data_size     = half_word;
                r0.deliver       = (svc_total_q != 8'd0) && (half_word != 16'd0);
                bytes_left_d     = half_word;
                if (half_word != 16'd0) begin
                  phase_d = PhData;
                end else begin
                  do_start = 1'b1;
                end
              end
            end
          end
          PhData: begin
            if (delivering_q) begin
              emit_r0         = 1'b1;
              r0.kind         = logo_mp_pkg::KindData;
              r0.logo_type    = type_q;
              r0.logo_id      = id_q;
              r0.payload_byte = data_byte_i;
            end
            bytes_left_d = bytes_left_dec;
            if (bytes_left_dec == 16'd0) begin
              do_start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // next entry or end of the entry loop
      if (do_start) begin
        if (ent == 16'd0) begin
          end_flag = 1'b1;
          end_st   = logo_mp_pkg::StOk;
        end else if (SW'(pos_d) + SW'(3) >= SW'(size_q)) begin
          end_flag = 1'b1;
          end_st   = logo_mp_pkg::StTrunc;
        end else begin
          entries_d = ent - 16'd1;
          phase_d   = PhEntry;
          bif_d     = '0;
          shift_d   = '0;
        end
      end

      if (end_flag) begin
        phase_d = PhDone;
      end
    end
  end

  // pack the results of this byte
  always_comb begin
    end_res        = '0;
    end_res.kind   = logo_mp_pkg::KindEnd;
    end_res.status = end_st;
  end

  assign pair_vld_o        = fire_i && (emit_r0 || end_flag);
  assign pair_o.res        = emit_r0 ? r0 : end_res;
  assign pair_o.two        = emit_r0 && end_flag;
  assign pair_o.end_status = end_st;

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      pos_q        <= '0;
      size_q       <= '0;
      entries_q    <= '0;
      type_q       <= '0;
      id_q         <= '0;
      svc_total_q  <= '0;
      svc_left_q   <= '0;
      shift_q      <= '0;
      bif_q        <= '0;
      bytes_left_q <= '0;
      delivering_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      size_q       <= size_d;
      entries_q    <= entries_d;
      type_q       <= type_d;
      id_q         <= id_d;
      svc_total_q  <= svc_total_d;
      svc_left_q   <= svc_left_d;
      shift_q      <= shift_d;
      bif_q        <= bif_d;
      bytes_left_q <= bytes_left_d;
      delivering_q <= delivering_d;
    end
  end

endmodule
